>>> rtl/wrs_pkg.sv
// ----------------------------------------------------------------------------
// wrs_pkg: shared types and constants for the water ripple stencil
// field widths, register indexes, reset values and the result queue item
// ----------------------------------------------------------------------------
package wrs_pkg;

    localparam int HEIGHT_BITS   = 16;
    localparam int COORD_BITS    = 8;
    localparam int GRID_CFG_BITS = 9;
    localparam int DAMP_BITS     = 16;
    localparam int DAMP_FRAC     = 16;
    localparam int MAX_SIZE_DEF  = 256;

    // result queue, in cells (each cell carries up to three results)
    localparam int QDEPTH    = 8;
    localparam int PEND_BITS = $clog2(QDEPTH + 1);

    // configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_SIZE = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DAMP      = 1'd1;

    localparam logic [GRID_CFG_BITS-1:0] GRID_RESET = 9'd256;
    localparam logic [DAMP_BITS-1:0]     DAMP_RESET = 16'd62415;

    typedef struct packed {
        logic                   last;
        logic [COORD_BITS-1:0]  y;
        logic [COORD_BITS-1:0]  x;
        logic [HEIGHT_BITS-1:0] h;
    } res_t;

    // one input cell's worth of results, r0 first on the output
    typedef struct packed {
        logic [1:0] cnt;
        res_t       r2;
        res_t       r1;
        res_t       r0;
    } q_item_t;

endpackage

>>> rtl/water_ripple_stencil_step.sv
// ----------------------------------------------------------------------------
// water_ripple_stencil_step: streaming water ripple update, one cell per beat
// a cell's results pass stage one, the lane registers and the queue before output
// throughput: one cell per cycle while the result queue has credit; in the last row
//   the output port carries two results per cell (three at the end), so input slows
// reset: synchronous, clears counters, queue and control registers to their defaults;
//   the row memories are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
module water_ripple_stencil_step
    import wrs_pkg::*;
#(
    parameter int MAX_SIZE = MAX_SIZE_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // input cells
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [31:0]               s_tdata,   // prev_height, cur_height
    // updated cells
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [31:0]               m_tdata,   // new_height, cell_x, cell_y
    output logic                      m_tlast,   // frame_last
    // register writes
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

    localparam int CW = $clog2(MAX_SIZE);   // column / row counter
    localparam int NW = CW + 1;             // holds the grid size itself
    localparam int AW = CW + 1;             // row parity and column

    // ------------------------------------------------------------------
    // grid size clamped to 2..MAX_SIZE
    // ------------------------------------------------------------------
    function automatic logic [NW-1:0] eff_size(input logic [GRID_CFG_BITS-1:0] g);
        logic [31:0] gv;
        gv = 32'(g);
        if (gv < 32'd2) begin
            gv = 32'd2;
        end else if (gv > 32'(MAX_SIZE)) begin
            gv = 32'(MAX_SIZE);
        end
        return NW'(gv);
    endfunction

    // configuration and raster position
    logic [NW-1:0]        size_reg;
    logic [DAMP_BITS-1:0] damp_reg;
    logic [CW-1:0]        col_reg;
    logic [CW-1:0]        row_reg;

    // accept side
    logic                 s_acc;
    logic                 last_col;
    logic                 last_row;
    logic                 acc_emit_a;
    logic [AW-1:0]        prev_wr_addr;
    logic [AW-1:0]        prev_rd_addr;
    logic [PEND_BITS-1:0] pend_reg;
    logic [PEND_BITS-1:0] pend_next;
    logic                 item_done;

    // stage one: memory data present
    logic                   s1_valid_reg;
    logic [HEIGHT_BITS-1:0] s1_pin_reg;
    logic [HEIGHT_BITS-1:0] s1_cin_reg;
    logic [CW-1:0]          s1_col_reg;
    logic [CW-1:0]          s1_row_reg;
    logic                   s1_first_col_reg;
    logic                   s1_second_col_reg;
    logic                   s1_last_col_reg;
    logic                   s1_row1_reg;
    logic                   s1_emit_a_reg;
    logic                   s1_emit_b_reg;
    logic                   s1_emit_c_reg;
    q_item_t                s1_meta;

    // recent inputs of this row
    logic [HEIGHT_BITS-1:0] pp1_reg;
    logic [HEIGHT_BITS-1:0] pp2_reg;
    logic [HEIGHT_BITS-1:0] pcin_reg;

    // line buffer outputs
    logic [HEIGHT_BITS-1:0] lb_right;
    logic [HEIGHT_BITS-1:0] lb_up;
    logic [HEIGHT_BITS-1:0] lb_cur;
    logic [HEIGHT_BITS-1:0] lb_self;
    logic [HEIGHT_BITS-1:0] lb_left;

    // lane operands
    logic [HEIGHT_BITS-1:0] a_left, a_right, a_up;
    logic [HEIGHT_BITS-1:0] b_left;
    logic [HEIGHT_BITS-1:0] ha, hb, hc;

    // later stages
    logic    s2_valid_reg;
    logic    s3_valid_reg;
    q_item_t s2_meta_reg;
    q_item_t s3_meta_reg;
    q_item_t push_item;
    res_t    out_res;

    // ------------------------------------------------------------------
    // input accept: one queue entry of credit per cell that has results
    // ------------------------------------------------------------------
    assign s_tready = (pend_reg < PEND_BITS'(QDEPTH));
    assign s_acc    = s_tvalid && s_tready;

    assign last_col   = ((NW'(col_reg) + NW'(1)) == size_reg);
    assign last_row   = ((NW'(row_reg) + NW'(1)) == size_reg);
    assign acc_emit_a = (row_reg != '0);

    // this cell goes to its row-parity half; up comes from the same slot,
    // which still holds the row two above. right looks one column ahead in
    // the row above, or at the end of a row fetches the start of this row
    assign prev_wr_addr = {row_reg[0], col_reg};
    assign prev_rd_addr = last_col ? {row_reg[0], CW'(0)}
                                   : {~row_reg[0], col_reg + CW'(1)};

    always_comb begin
        unique case ({s_acc && acc_emit_a, item_done})
            2'b10:   pend_next = pend_reg + PEND_BITS'(1);
            2'b01:   pend_next = pend_reg - PEND_BITS'(1);
            default: pend_next = pend_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg     <= eff_size(GRID_RESET);
            damp_reg     <= DAMP_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            pend_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            // a grid size write restarts the frame
            if (cfg_wr_en && (cfg_index == REG_GRID_SIZE)) begin
                size_reg <= eff_size(cfg_wdata[GRID_CFG_BITS-1:0]);
                col_reg  <= '0;
                row_reg  <= '0;
            end else if (s_acc) begin
                if (last_col) begin
                    col_reg <= '0;
                    if (last_row) begin
                        row_reg <= '0;
                    end else begin
                        row_reg <= row_reg + CW'(1);
                    end
                end else begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            if (cfg_wr_en && (cfg_index == REG_DAMP)) begin
                damp_reg <= cfg_wdata[DAMP_BITS-1:0];
            end
            pend_reg     <= pend_next;
            s1_valid_reg <= s_acc;
            // row-0 cells only fill the buffers and leave the pipe here
            s2_valid_reg <= s1_valid_reg && s1_emit_a_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_pin_reg        <= s_tdata[15:0];
            s1_cin_reg        <= s_tdata[31:16];
            s1_col_reg        <= col_reg;
            s1_row_reg        <= row_reg;
            s1_first_col_reg  <= (col_reg == '0);
            s1_second_col_reg <= (col_reg == CW'(1));
            s1_last_col_reg   <= last_col;
            s1_row1_reg       <= (row_reg == CW'(1));
            s1_emit_a_reg     <= acc_emit_a;
            s1_emit_b_reg     <= last_row && (col_reg != '0);
            s1_emit_c_reg     <= last_row && last_col;
        end
        if (s1_valid_reg) begin
            pp2_reg  <= pp1_reg;
            pp1_reg  <= s1_pin_reg;
            pcin_reg <= s1_cin_reg;
        end
        s2_meta_reg <= s1_meta;
        s3_meta_reg <= s2_meta_reg;
    end

    // ------------------------------------------------------------------
    // row memories
    // ------------------------------------------------------------------
    wrs_line_buf #(
        .MAX_SIZE (MAX_SIZE)
    ) u_line_buf (
        .aclk         (aclk),
        .acc          (s_acc),
        .prev_wr_addr (prev_wr_addr),
        .prev_rd_addr (prev_rd_addr),
        .cur_addr     (col_reg),
        .prev_wr_data (s_tdata[15:0]),
        .cur_wr_data  (s_tdata[31:16]),
        .shift        (s1_valid_reg),
        .right_q      (lb_right),
        .up_q         (lb_up),
        .cur_q        (lb_cur),
        .self_q       (lb_self),
        .left_q       (lb_left)
    );

    // ------------------------------------------------------------------
    // stage one: neighbours for the three possible results
    //   lane a: the cell above this one, down is this input
    //   lane b: last row, the cell to the left (its down clamps to itself)
    //   lane c: last row, this cell at the final column
    // ------------------------------------------------------------------
    assign a_left  = s1_first_col_reg ? lb_self : lb_left;
    assign a_right = s1_last_col_reg  ? lb_self : lb_right;
    assign a_up    = s1_row1_reg      ? lb_self : lb_up;
    assign b_left  = s1_second_col_reg ? pp1_reg : pp2_reg;

    always_comb begin
        s1_meta         = '0;
        s1_meta.cnt     = 2'd1 + {1'b0, s1_emit_b_reg} + {1'b0, s1_emit_c_reg};
        s1_meta.r0.x    = COORD_BITS'(s1_col_reg);
        s1_meta.r0.y    = COORD_BITS'(s1_row_reg - CW'(1));
        s1_meta.r1.x    = COORD_BITS'(s1_col_reg - CW'(1));
        s1_meta.r1.y    = COORD_BITS'(s1_row_reg);
        s1_meta.r2.x    = COORD_BITS'(s1_col_reg);
        s1_meta.r2.y    = COORD_BITS'(s1_row_reg);
        s1_meta.r2.last = 1'b1;
    end

    wrs_lane u_lane_a (
        .aclk  (aclk),
        .left  (a_left),
        .right (a_right),
        .up    (a_up),
        .down  (s1_pin_reg),
        .cur   (lb_cur),
        .damp  (damp_reg),
        .new_h (ha)
    );

    wrs_lane u_lane_b (
        .aclk  (aclk),
        .left  (b_left),
        .right (s1_pin_reg),
        .up    (lb_left),
        .down  (pp1_reg),
        .cur   (pcin_reg),
        .damp  (damp_reg),
        .new_h (hb)
    );

    wrs_lane u_lane_c (
        .aclk  (aclk),
        .left  (pp1_reg),
        .right (s1_pin_reg),
        .up    (lb_self),
        .down  (s1_pin_reg),
        .cur   (s1_cin_reg),
        .damp  (damp_reg),
        .new_h (hc)
    );

    // ------------------------------------------------------------------
    // stage three: results into the queue
    // ------------------------------------------------------------------
    always_comb begin
        push_item      = s3_meta_reg;
        push_item.r0.h = ha;
        push_item.r1.h = hb;
        push_item.r2.h = hc;
    end

    wrs_out_queue u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s3_valid_reg),
        .push_item (push_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res),
        .item_done (item_done)
    );

    assign m_tdata = {out_res.y, out_res.x, out_res.h};
    assign m_tlast = out_res.last;

`ifndef SYNTH
    // a queued result always has its cell's credit outstanding
    a_out_has_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (pend_reg != '0))
        else $error("result beat offered with no credit outstanding");

    // a cell in the arithmetic pipe is counted
    a_pipe_has_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        s3_valid_reg |-> (pend_reg != '0))
        else $error("cell in flight with no credit outstanding");

    // taking a cell that will give results claims exactly one entry
    a_credit_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && acc_emit_a && !item_done)
            |=> (pend_reg == ($past(pend_reg) + PEND_BITS'(1))))
        else $error("credit not taken on cell accept");
`endif

endmodule

>>> rtl/wrs_line_buf.sv
// ----------------------------------------------------------------------------
// wrs_line_buf: row memories and neighbour window
// two-row previous-height memory, current-row memory, read-first on overlap
// ----------------------------------------------------------------------------
module wrs_line_buf
    import wrs_pkg::*;
#(
    parameter int MAX_SIZE = MAX_SIZE_DEF
) (
    input  logic                   aclk,
    input  logic                   acc,
    input  logic [$clog2(MAX_SIZE):0]   prev_wr_addr,
    input  logic [$clog2(MAX_SIZE):0]   prev_rd_addr,
    input  logic [$clog2(MAX_SIZE)-1:0] cur_addr,
    input  logic [HEIGHT_BITS-1:0] prev_wr_data,
    input  logic [HEIGHT_BITS-1:0] cur_wr_data,
    input  logic                   shift,
    output logic [HEIGHT_BITS-1:0] right_q,
    output logic [HEIGHT_BITS-1:0] up_q,
    output logic [HEIGHT_BITS-1:0] cur_q,
    output logic [HEIGHT_BITS-1:0] self_q,
    output logic [HEIGHT_BITS-1:0] left_q
);

    localparam int CW = $clog2(MAX_SIZE);
    localparam int AW = CW + 1;

    logic [HEIGHT_BITS-1:0] prev_mem [2**AW];
    logic [HEIGHT_BITS-1:0] cur_mem  [2**CW];

    logic [HEIGHT_BITS-1:0] right_reg;
    logic [HEIGHT_BITS-1:0] up_reg;
    logic [HEIGHT_BITS-1:0] cur_reg;
    logic [HEIGHT_BITS-1:0] self_reg;
    logic [HEIGHT_BITS-1:0] left_reg;

    // up shares the write address: old contents come out, new go in
    always_ff @(posedge aclk) begin
        if (acc) begin
            prev_mem[prev_wr_addr] <= prev_wr_data;
            cur_mem[cur_addr]      <= cur_wr_data;
            right_reg              <= prev_mem[prev_rd_addr];
            up_reg                 <= prev_mem[prev_wr_addr];
            cur_reg                <= cur_mem[cur_addr];
        end
    end

    // window along the upper row: self and left trail the look-ahead read
    always_ff @(posedge aclk) begin
        if (shift) begin
            self_reg <= right_reg;
            left_reg <= self_reg;
        end
    end

    assign right_q = right_reg;
    assign up_q    = up_reg;
    assign cur_q   = cur_reg;
    assign self_q  = self_reg;
    assign left_q  = left_reg;

endmodule

>>> rtl/wrs_lane.sv
// ----------------------------------------------------------------------------
// wrs_lane: one cell update
// halve the neighbour sum, subtract current height, damp, round to zero, clip
// ----------------------------------------------------------------------------
module wrs_lane
    import wrs_pkg::*;
(
    input  logic                          aclk,
    input  logic signed [HEIGHT_BITS-1:0] left,
    input  logic signed [HEIGHT_BITS-1:0] right,
    input  logic signed [HEIGHT_BITS-1:0] up,
    input  logic signed [HEIGHT_BITS-1:0] down,
    input  logic signed [HEIGHT_BITS-1:0] cur,
    input  logic        [DAMP_BITS-1:0]   damp,
    output logic        [HEIGHT_BITS-1:0] new_h
);

    localparam int SW = HEIGHT_BITS + 2;
    localparam int PW = SW + DAMP_BITS + 1;
    localparam int QW = PW - DAMP_FRAC;

    localparam logic signed [QW-1:0] Q_HI = QW'((2 ** (HEIGHT_BITS - 1)) - 1);
    localparam logic signed [QW-1:0] Q_LO = ~Q_HI;
    localparam logic signed [PW-1:0] RND  = PW'((2 ** DAMP_FRAC) - 1);

    logic signed [SW-1:0]        sum;
    logic signed [SW-1:0]        sum_adj;
    logic signed [SW-1:0]        half;
    logic signed [SW-1:0]        v_next;
    logic signed [SW-1:0]        v_reg;
    logic signed [DAMP_BITS:0]   damp_s;
    logic signed [PW-1:0]        p_next;
    logic signed [PW-1:0]        p_reg;
    logic signed [PW-1:0]        bias;
    logic signed [PW-1:0]        p_adj;
    logic signed [QW-1:0]        q;

    // stage one: sum, halve towards zero, subtract
    assign sum     = SW'(left) + SW'(right) + SW'(up) + SW'(down);
    assign sum_adj = sum + $signed({{(SW-1){1'b0}}, sum[SW-1]});
    assign half    = sum_adj >>> 1;
    assign v_next  = half - SW'(cur);

    // stage two: damping multiply
    assign damp_s = $signed({1'b0, damp});
    assign p_next = v_reg * damp_s;

    always_ff @(posedge aclk) begin
        v_reg <= v_next;
        p_reg <= p_next;
    end

    // stage three: drop the fraction towards zero, clip
    always_comb begin
        if (p_reg[PW-1]) begin
            bias = RND;
        end else begin
            bias = '0;
        end
    end

    assign p_adj = p_reg + bias;
    assign q     = QW'(p_adj >>> DAMP_FRAC);

    always_comb begin
        if (q > Q_HI) begin
            new_h = Q_HI[HEIGHT_BITS-1:0];
        end else if (q < Q_LO) begin
            new_h = Q_LO[HEIGHT_BITS-1:0];
        end else begin
            new_h = q[HEIGHT_BITS-1:0];
        end
    end

endmodule

>>> rtl/wrs_out_queue.sv
// ----------------------------------------------------------------------------
// wrs_out_queue: result queue and serialiser
// holds one entry per cell and sends its one to three results a beat each
// ----------------------------------------------------------------------------
module wrs_out_queue
    import wrs_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  q_item_t push_item,
    output logic    out_valid,
    input  logic    out_ready,
    output res_t    out_res,
    output logic    item_done
);

    localparam int PTRW = $clog2(QDEPTH);
    localparam int CNTW = $clog2(QDEPTH + 1);

    q_item_t q_mem [QDEPTH];

    logic [PTRW-1:0] wr_ptr_reg;
    logic [PTRW-1:0] rd_ptr_reg;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;
    logic [1:0]      sub_reg;
    logic [1:0]      sub_next;
    q_item_t         head;
    logic            beat;

    assign head      = q_mem[rd_ptr_reg];
    assign out_valid = (count_reg != '0);
    assign beat      = out_valid && out_ready;
    assign item_done = beat && ((sub_reg + 2'd1) == head.cnt);

    always_comb begin
        unique case (sub_reg)
            2'd0:    out_res = head.r0;
            2'd1:    out_res = head.r1;
            default: out_res = head.r2;
        endcase
    end

    always_comb begin
        if (item_done) begin
            sub_next = 2'd0;
        end else if (beat) begin
            sub_next = sub_reg + 2'd1;
        end else begin
            sub_next = sub_reg;
        end
    end

    always_comb begin
        unique case ({push, item_done})
            2'b10:   count_next = count_reg + CNTW'(1);
            2'b01:   count_next = count_reg - CNTW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTRW'(1);
            end
            if (item_done) begin
                rd_ptr_reg <= rd_ptr_reg + PTRW'(1);
            end
            count_reg <= count_next;
            sub_reg   <= sub_next;
        end
    end

endmodule

>>> tb/water_ripple_stencil_step_test.sv
// ----------------------------------------------------------------------------
// water_ripple_stencil_step_test: self-checking bench for the ripple stencil
// streams height cells in raster order and predicts every updated cell from a
// behavioural copy of the row buffers, clamped neighbours and Q0.16 damping.
// Covers reset defaults, grid clamping, saturation, rounding toward zero,
// frame restart, back-pressure and randomised frames with random idling.
// ----------------------------------------------------------------------------
module water_ripple_stencil_step_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wrs_pkg::*;

    localparam int          RANDOM_CELLS  = 100;
    localparam int          SETTLE_CYCLES = 12;      // lets the pipeline drain, with margin
    localparam int          HOLD_CYCLES   = 300;     // long receiver stall
    localparam int unsigned CYCLE_LIMIT   = 400000;

    // ------------------------------------------------------------------------
    // block ports
    // ------------------------------------------------------------------------
    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [31:0]               s_tdata   = '0;      // prev_height, cur_height
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [31:0]               m_tdata;             // new_height, cell_x, cell_y
    logic                      m_tlast;             // frame_last
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

    water_ripple_stencil_step dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // stencil predictor state
    // ------------------------------------------------------------------------
    // two previous-frame rows, selected by row parity
    logic signed [15:0]     prev_rows_mem [0:2*MAX_SIZE_DEF-1];
    // current heights of the most recent row
    logic signed [15:0]     cur_row_mem [0:MAX_SIZE_DEF-1];
    // previous heights of the last two beats in this row
    logic signed [15:0]     recent_prev [2];
    int unsigned            col_pos;
    int unsigned            row_pos;
    logic [GRID_CFG_BITS-1:0] grid_reg;
    logic [DAMP_BITS-1:0]   damp_reg;

    res_t                   expected_cells [$];
    int                     mismatch_count = 0;

    // stimulus controls shared with the sender and receiver
    bit                     tx_idle_on = 1'b0;
    bit                     rx_idle_on = 1'b0;
    int                     rx_hold_cycles = 0;

    function automatic int unsigned eff_grid();
        if (grid_reg < 2) return 2;
        if (grid_reg > MAX_SIZE_DEF) return MAX_SIZE_DEF;
        return grid_reg;
    endfunction

    function automatic int unsigned row_slot(input int unsigned row, input int unsigned col);
        return (row & 1) * MAX_SIZE_DEF + col;
    endfunction

    // half the neighbour sum minus the current height, damped and saturated
    function automatic logic [15:0] damped_height(input int l, input int r, input int u,
                                                  input int d, input int c);
        longint total;
        longint diff;
        longint damp_l;
        longint prod;
        total  = longint'(l) + r + u + d;
        diff   = total / 2 - c;          // truncates toward zero
        damp_l = damp_reg;
        prod   = diff * damp_l;
        if (prod < 0) prod = -((-prod) >>> DAMP_FRAC);
        else          prod = prod >>> DAMP_FRAC;
        if (prod > 32767)  prod = 32767;
        if (prod < -32768) prod = -32768;
        return prod[15:0];
    endfunction

    function automatic void push_cell(input logic [15:0] h, input int unsigned x,
                                      input int unsigned y, input logic last);
        res_t exp_res;
        exp_res.h    = h;
        exp_res.x    = x[7:0];
        exp_res.y    = y[7:0];
        exp_res.last = last;
        expected_cells.push_back(exp_res);
    endfunction

    // one accepted input cell below row 0: emits the cell above, and in the last row the
    // cell to the left plus, at the final column, the frame's final cell
    function automatic void stencil_cell(input logic signed [15:0] pin,
                                         input logic signed [15:0] cin);
        int unsigned n;
        int unsigned x;
        int unsigned y;
        int unsigned ym;
        int          self_h;
        int          l;
        int          r;
        int          u;
        int          c;
        n = eff_grid();
        x = col_pos;
        y = row_pos;
        if (x >= n || y >= n) begin
            x = 0;
            y = 0;
        end
        if (y >= 1) begin
            ym     = y - 1;
            self_h = prev_rows_mem[row_slot(ym, x)];
            l      = (x > 0)     ? prev_rows_mem[row_slot(ym, x - 1)] : self_h;
            r      = (x + 1 < n) ? prev_rows_mem[row_slot(ym, x + 1)] : self_h;
            u      = (ym > 0)    ? prev_rows_mem[row_slot(y, x)]      : self_h;
            push_cell(damped_height(l, r, u, pin, cur_row_mem[x]), x, ym, 1'b0);
            if (y == n - 1) begin
                if (x >= 1) begin
                    c = recent_prev[0];
                    l = (x - 1 > 0) ? recent_prev[1] : c;
                    u = prev_rows_mem[row_slot(ym, x - 1)];
                    push_cell(damped_height(l, pin, u, c, cur_row_mem[x - 1]),
                              x - 1, y, 1'b0);
                end
                if (x == n - 1) begin
                    u = prev_rows_mem[row_slot(ym, x)];
                    push_cell(damped_height(recent_prev[0], pin, u, pin, cin), x, y, 1'b1);
                end
            end
        end
        prev_rows_mem[row_slot(y, x)] = pin;
        cur_row_mem[x]                = cin;
        recent_prev[1]                = recent_prev[0];
        recent_prev[0]                = pin;
        x++;
        if (x >= n) begin
            x = 0;
            y++;
            if (y >= n) y = 0;
        end
        col_pos = x;
        row_pos = y;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                                            input logic [CFG_DATA_BITS-1:0] val);
        case (idx)
            REG_GRID_SIZE: begin
                grid_reg = val[GRID_CFG_BITS-1:0];
                col_pos  = 0;        // frame restarts at (0,0)
                row_pos  = 0;
            end
            REG_DAMP: begin
                damp_reg = val[DAMP_BITS-1:0];
            end
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("tb: %s mismatch, got %0d expected %0d", what, got, want);
    endtask

    task automatic check_result();
        res_t want;
        if (expected_cells.size() == 0) begin
            flag_mismatch("unexpected beat, tdata", int'(m_tdata), 0);
            return;
        end
        want = expected_cells.pop_front();
        if (m_tdata[15:0] !== want.h)
            flag_mismatch("new_height", $signed(m_tdata[15:0]), $signed(want.h));
        if (m_tdata[23:16] !== want.x)
            flag_mismatch("cell_x", m_tdata[23:16], want.x);
        if (m_tdata[31:24] !== want.y)
            flag_mismatch("cell_y", m_tdata[31:24], want.y);
        if (m_tlast !== want.last)
            flag_mismatch("frame_last", m_tlast, want.last);
    endtask

    // ------------------------------------------------------------------------
    // monitor: register writes, accepted cells and accepted results, all
    // sampled at the edge before any of this edge's updates land
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            grid_reg       = GRID_RESET;
            damp_reg       = DAMP_RESET;
            col_pos        = 0;
            row_pos        = 0;
            recent_prev[0] = '0;
            recent_prev[1] = '0;
            expected_cells.delete();
        end else begin
            if (cfg_wr_en) apply_reg_write(cfg_index, cfg_wdata);
            if (s_tvalid && s_tready) stencil_cell(s_tdata[15:0], s_tdata[31:16]);
            if (m_tvalid && m_tready) check_result();
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random per-beat stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        forever begin
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end
            gap = rx_idle_on ? $urandom_range(0, 16) : 0;
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            // leave on an accepted beat, or early when a hold-off is asked for
            do @(posedge aclk); while (!m_tvalid && rx_hold_cycles == 0);
        end
    end

    // run limit
    initial begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // sender side helpers, each entered just after a rising edge
    // ------------------------------------------------------------------------
    task automatic send_cell(input logic [15:0] prev_h, input logic [15:0] cur_h);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 16) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cur_h, prev_h};
        do @(posedge aclk); while (!s_tready);
    endtask

    // drop valid, let the monitor take the last beat, wait for every pending
    // cell, then let row-0 work settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_cells.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_height();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            3, 4:    return 16'($urandom_range(0, 127) - 64);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [15:0] rand_damp();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2:       return DAMP_RESET;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset size and damping: a full row 0 plus the first cell of row 1
    // gives a single result only on a 256-wide grid
    task automatic test_reset_defaults();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (MAX_SIZE_DEF + 1) send_cell(rand_height(), rand_height());
        wait_idle();
    endtask

    // smallest grid at both undersized settings, saturation both ways, zero
    // damping and halving of odd negative sums
    task automatic test_saturation_and_rounding();
        int i;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        write_reg(REG_GRID_SIZE, 16'd0);
        write_reg(REG_DAMP, 16'hffff);
        repeat (4) send_cell(16'h7fff, 16'h8000);
        // second frame right after the wrap to (0,0)
        repeat (4) send_cell(16'h8000, 16'h7fff);
        wait_idle();
        write_reg(REG_GRID_SIZE, 16'd1);
        write_reg(REG_DAMP, 16'h0000);
        send_cell(16'h7fff, 16'h7fff);
        send_cell(16'h8000, 16'h0001);
        send_cell(16'h0000, 16'hffff);
        send_cell(16'hffff, 16'h8000);
        wait_idle();
        write_reg(REG_GRID_SIZE, 16'd3);
        write_reg(REG_DAMP, 16'h8000);
        for (i = 0; i < 9; i++) send_cell(16'(3 * i - 13), 16'(7 - 5 * i));
        wait_idle();
    endtask

    // grid write mid-frame restarts at (0,0); damping write mid-frame
    task automatic test_frame_restart();
        write_reg(REG_GRID_SIZE, 16'd4);
        write_reg(REG_DAMP, DAMP_RESET);
        repeat (7) send_cell(rand_height(), rand_height());
        wait_idle();
        write_reg(REG_GRID_SIZE, 16'd4);
        repeat (10) send_cell(rand_height(), rand_height());
        wait_idle();
        write_reg(REG_DAMP, 16'd40000);
        repeat (6) send_cell(rand_height(), rand_height());
        wait_idle();
    endtask

    // receiver stalls long enough for the block to back up its input; then
    // the sender pauses mid-frame until every pending cell is out
    task automatic test_backpressure();
        write_reg(REG_GRID_SIZE, 16'd8);
        write_reg(REG_DAMP, rand_damp());
        tx_idle_on     = 1'b0;
        rx_idle_on     = 1'b0;
        rx_hold_cycles = HOLD_CYCLES;
        repeat (32) send_cell(rand_height(), rand_height());
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (16) send_cell(rand_height(), rand_height());
        wait_idle();
        repeat (16) send_cell(rand_height(), rand_height());
        wait_idle();
    endtask

    // mostly whole frames on small grids with random content; some cut short
    // and restarted by the next grid write
    task automatic test_random_frames();
        int unsigned              side;
        int unsigned              cells;
        int unsigned              sent;
        int unsigned              pick;
        logic [CFG_DATA_BITS-1:0] grid_word;
        sent = 0;
        while (sent < RANDOM_CELLS) begin
            pick = $urandom_range(0, 19);
            if (pick < 12)      side = $urandom_range(2, 6);
            else if (pick < 18) side = $urandom_range(7, 12);
            else                side = $urandom_range(13, 16);
            grid_word = 16'(side);
            if (side == 2 && $urandom_range(0, 1)) grid_word = 16'($urandom_range(0, 1));
            // junk above the register width is dropped
            if ($urandom_range(0, 7) == 0) grid_word[15:9] = 7'($urandom_range(1, 127));
            write_reg(REG_GRID_SIZE, grid_word);
            if ($urandom_range(0, 1)) write_reg(REG_DAMP, rand_damp());
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0) cells = $urandom_range(1, side * side - 1);
            else cells = side * side * ((side < 7) ? $urandom_range(1, 3) : 1);
            repeat (cells) send_cell(rand_height(), rand_height());
            sent += cells;
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_saturation_and_rounding();
        test_frame_restart();
        test_backpressure();
        test_random_frames();
        wait_idle();
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/wrs_pkg.sv
rtl/wrs_line_buf.sv
rtl/wrs_lane.sv
rtl/wrs_out_queue.sv
rtl/water_ripple_stencil_step.sv
tb/water_ripple_stencil_step_test.sv
